/* rtl/lotp_pkg.sv */
package lotp_pkg;

	localparam int COORD_W    = 32;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int LEN_W      = COORD_W + 1;
	localparam int OP_W       = SQ_W + 2;
	localparam int SREM_W     = COORD_W + 5;
	localparam int NUM_W      = SQ_W + 1;
	localparam int DREM_W     = COORD_W + 2;
	localparam int SQRT_STEPS = COORD_W + 1;
	localparam int DIV_STEPS  = SQ_W + 1;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int CFG_W      = 16;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [CFG_W-1:0] MIN_LEN_RESET = CFG_W'(1);

	localparam logic CMD_POS   = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	localparam logic [1:0] STAT_SIGNED = 2'd0;
	localparam logic [1:0] STAT_SINGLE = 2'd1;
	localparam logic [1:0] STAT_DEGEN  = 2'd2;
	localparam logic [1:0] STAT_NONE   = 2'd3;

	localparam logic [COORD_W-1:0] MAX_POS = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] CAP     = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} lotp_point_t;

	typedef struct packed {
		logic [1:0]      status;
		logic            fwd;
		logic [SQ_W-1:0] dist_sq;
		lotp_point_t     best;
		lotp_point_t     other;
		lotp_point_t     veh;
	} lotp_job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_LEN,
		ST_SQRT,
		ST_DIV,
		ST_OUT
	} lotp_state_t;

	function automatic logic signed [COORD_W:0] sdiff(input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

	function automatic logic [COORD_W-1:0] smag(input logic signed [COORD_W:0] v);
		logic [COORD_W:0] n;
		n = v[COORD_W] ? -v : v;
		return n[COORD_W-1:0];
	endfunction

	function automatic logic [COORD_W-1:0] sat_pos(input logic [LEN_W-1:0] v);
		return (v > LEN_W'(MAX_POS)) ? MAX_POS : v[COORD_W-1:0];
	endfunction

endpackage

/* rtl/lateral_offset_to_polyline.sv */
// Signed cross-track error of a vehicle against a lane polyline, in Q15.16.
// Push a position request (cmd 0) to load the vehicle and start a query, then
// push lane point requests (cmd 1), the final one with last_point set; one
// result comes out per final point, and one for a position request that has
// last_point set (status 3, no points). The front end takes one request per
// cycle while full is low: a two-stage squared-distance compare keeps the
// nearest point, its predecessor and its successor. A final point hands a
// query to a two-entry queue and the back end works it out with a shared
// one-bit-per-cycle unit: a signed result takes tangent setup, a 33-step
// square root, a 65-step division and the output load. The front end keeps
// taking points while the back end works; full rises only when the queue is
// full and another query finishes. Results wait in an output register until
// popped. min_tangent_len (reset 1) is written through the cfg channel, which
// is always ready; write it only while the block is idle.
module lateral_offset_to_polyline import lotp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	// request side
	input  logic                      push,
	output logic                      full,
	input  logic                      cmd,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic                      last_point,
	// result side
	output logic                      empty,
	input  logic                      pop,
	output logic signed [COORD_W-1:0] lateral_error,
	output logic [1:0]                status,
	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_W-1:0]          cfg_data
);

	logic min_len_wr;
	logic [CFG_W-1:0] min_len_q;
	logic job_push, q_full, job_avail, job_pop;
	lotp_job_t job_in, job_out;
	logic [COORD_W-1:0] err_raw;

	assign cfg_ready     = 1'b1;
	assign min_len_wr    = cfg_valid && cfg_ready;
	assign lateral_error = err_raw;

	// hold the tangent threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_len_q <= MIN_LEN_RESET;
		else if (min_len_wr)
			min_len_q <= cfg_data;
	end

	// front end: nearest-point tracking, one request per cycle while full is low
	lotp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.last_point (last_point),
		.job_push   (job_push),
		.job        (job_in),
		.fifo_full  (q_full)
	);

	// finished queries wait here for the back end
	lotp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_push),
		.wdata  (job_in),
		.full   (q_full),
		.rd     (job_pop),
		.rdata  (job_out),
		.avail  (job_avail)
	);

	// back end: tangent length, cross product, division or plain distance, output register
	lotp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_avail       (job_avail),
		.job             (job_out),
		.job_pop         (job_pop),
		.min_tangent_len (min_len_q),
		.pop             (pop),
		.empty           (empty),
		.lateral_error   (err_raw),
		.status          (status)
	);

endmodule

/* rtl/lotp_front.sv */
module lotp_front import lotp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      cmd,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic                      last_point,
	output logic                      job_push,
	output lotp_job_t                 job,
	input  logic                      fifo_full
);

	logic stall, accept;

	lotp_point_t veh_q, tveh_q, best_q, before_q, after_q, prev_q;
	logic [SQ_W-1:0] best_dist_q;
	logic [1:0] cnt_q;
	logic fb_q, fp_q, fa_q;

	logic valid_s1, cmd_s1, last_s1;
	lotp_point_t pt_s1;
	logic [COORD_W-1:0] mdx_s1, mdy_s1;

	logic valid_s2, cmd_s2, last_s2;
	lotp_point_t pt_s2;
	logic [SQ_W-1:0] sqx_s2, sqy_s2;

	logic [SQ_W:0] sum;
	logic [SQ_W-1:0] d2, best_dist_n;
	logic take;
	lotp_point_t best_n, before_n, after_n;
	logic [1:0] cnt_n;
	logic fb_n, fp_n, fa_n;
	lotp_point_t in_pt;

	assign stall    = valid_s2 && last_s2 && fifo_full;
	assign full     = stall;
	assign accept   = push && !stall;
	assign job_push = valid_s2 && last_s2 && !fifo_full;
	assign in_pt    = '{y: pos_y, x: pos_x};

	always_comb begin
		sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		d2 = sum[SQ_W] ? '1 : sum[SQ_W-1:0];
		take = (cnt_q == 2'd0) || (d2 < best_dist_q);
		best_dist_n = best_dist_q;
		best_n = best_q;
		before_n = before_q;
		after_n = after_q;
		fb_n = fb_q;
		fp_n = fp_q;
		fa_n = fa_q;
		if (take) begin
			before_n = prev_q;
			best_n = pt_s2;
			best_dist_n = d2;
			fb_n = (cnt_q != 2'd0);
			fa_n = 1'b0;
			fp_n = 1'b1;
		end else if (fp_q) begin
			after_n = pt_s2;
			fp_n = 1'b0;
			fa_n = 1'b1;
		end
		cnt_n = (cnt_q == 2'd2) ? cnt_q : cnt_q + 2'd1;
		if (cmd_s2 == CMD_POS)
			job.status = STAT_NONE;
		else
			job.status = (cnt_n == 2'd2) ? STAT_SIGNED : STAT_SINGLE;
		job.fwd = fa_n;
		job.dist_sq = best_dist_n;
		job.best = best_n;
		job.other = fa_n ? after_n : before_n;
		job.veh = tveh_q;
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (!stall) begin
			cmd_s2 <= cmd_s1;
			last_s2 <= last_s1;
			pt_s2 <= pt_s1;
			sqx_s2 <= SQ_W'(mdx_s1) * SQ_W'(mdx_s1);
			sqy_s2 <= SQ_W'(mdy_s1) * SQ_W'(mdy_s1);
			if (accept) begin
				cmd_s1 <= cmd;
				last_s1 <= last_point;
				pt_s1 <= in_pt;
				mdx_s1 <= smag(sdiff(pos_x, veh_q.x));
				mdy_s1 <= smag(sdiff(pos_y, veh_q.y));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			veh_q <= '0;
			tveh_q <= '0;
			best_q <= '0;
			before_q <= '0;
			after_q <= '0;
			prev_q <= '0;
			best_dist_q <= '1;
			cnt_q <= 2'd0;
			fb_q <= 1'b0;
			fp_q <= 1'b0;
			fa_q <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			if (accept && cmd == CMD_POS)
				veh_q <= in_pt;
			if (valid_s2) begin
				if (cmd_s2 == CMD_POS || last_s2) begin
					// drop the tracking: new query or finished polyline
					if (cmd_s2 == CMD_POS)
						tveh_q <= pt_s2;
					best_dist_q <= '1;
					cnt_q <= 2'd0;
					fb_q <= 1'b0;
					fp_q <= 1'b0;
					fa_q <= 1'b0;
				end else begin
					best_dist_q <= best_dist_n;
					best_q <= best_n;
					before_q <= before_n;
					after_q <= after_n;
					prev_q <= pt_s2;
					cnt_q <= cnt_n;
					fb_q <= fb_n;
					fp_q <= fp_n;
					fa_q <= fa_n;
				end
			end
		end
	end

endmodule

/* rtl/lotp_fifo.sv */
module lotp_fifo import lotp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr,
	input  lotp_job_t wdata,
	output logic      full,
	input  logic      rd,
	output lotp_job_t rdata,
	output logic      avail
);

	lotp_job_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wp_q, rp_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign avail = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/lotp_back.sv */
module lotp_back import lotp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_avail,
	input  lotp_job_t           job,
	output logic                job_pop,
	input  logic [CFG_W-1:0]    min_tangent_len,
	input  logic                pop,
	output logic                empty,
	output logic [COORD_W-1:0]  lateral_error,
	output logic [1:0]          status
);

	lotp_state_t state_q, state_n;

	lotp_job_t job_q;
	logic [COORD_W-1:0] tmx_q, tmy_q, dmx_q, dmy_q;
	logic tnx_q, tny_q, dnx_q, dny_q;
	logic [SQ_W-1:0] sqx_q, sqy_q, m1_q, m2_q;
	logic [OP_W-1:0] op_q;
	logic [SREM_W-1:0] srem_q;
	logic [LEN_W-1:0] root_q, len_q;
	logic [NUM_W-1:0] num_q;
	logic [DREM_W-1:0] drem_q;
	logic [COORD_W-1:0] quo_q;
	logic neg_q, sq_len_q;
	logic [STEP_W-1:0] step_q;
	logic [COORD_W-1:0] err_q;
	logic [1:0] stat_q;
	logic out_valid_q;
	logic [COORD_W-1:0] out_err_q;
	logic [1:0] out_stat_q;

	logic step_last, degen, load_out;
	logic signed [COORD_W:0] tx, ty, dx, dy;
	logic [SREM_W-1:0] srem_sh, trial, srem_n;
	logic sge;
	logic [LEN_W-1:0] root_n;
	logic [DREM_W-1:0] drem_sh, drem_n;
	logic dge;
	logic [COORD_W:0] quo_sh;
	logic [COORD_W-1:0] quo_n, quo_neg, div_err;
	logic s1, s2;
	logic [NUM_W-1:0] num_n;
	logic neg_n;

	assign step_last     = (step_q == '0);
	assign job_pop       = (state_q == ST_IDLE) && job_avail;
	assign load_out      = (state_q == ST_OUT) && (!out_valid_q || pop);
	assign empty         = !out_valid_q;
	assign lateral_error = out_err_q;
	assign status        = out_stat_q;

	always_comb begin
		tx = job_q.fwd ? sdiff(job_q.other.x, job_q.best.x) : sdiff(job_q.best.x, job_q.other.x);
		ty = job_q.fwd ? sdiff(job_q.other.y, job_q.best.y) : sdiff(job_q.best.y, job_q.other.y);
		dx = sdiff(job_q.veh.x, job_q.best.x);
		dy = sdiff(job_q.veh.y, job_q.best.y);

		// one restoring square-root digit
		srem_sh = {srem_q[SREM_W-3:0], op_q[OP_W-1 -: 2]};
		trial = SREM_W'({root_q, 2'b01});
		sge = (srem_sh >= trial);
		srem_n = sge ? srem_sh - trial : srem_sh;
		root_n = {root_q[LEN_W-2:0], sge};
		degen = (root_n == '0) || (root_n < LEN_W'(min_tangent_len));

		// one restoring division bit, quotient clamped just above the cap
		drem_sh = {drem_q[DREM_W-2:0], num_q[NUM_W-1]};
		dge = (drem_sh >= DREM_W'(len_q));
		drem_n = dge ? drem_sh - DREM_W'(len_q) : drem_sh;
		quo_sh = {quo_q, dge};
		quo_n = (quo_sh > (COORD_W+1)'(CAP)) ? CAP + 1'b1 : quo_sh[COORD_W-1:0];
		quo_neg = (quo_n > CAP) ? CAP : quo_n;
		if (neg_q)
			div_err = -quo_neg;
		else
			div_err = (quo_n > MAX_POS) ? MAX_POS : quo_n;

		// combine the two cross-product terms by sign
		s1 = (m1_q == '0) ? !(dnx_q != tny_q) : (dny_q != tnx_q);
		s2 = (m2_q == '0) ? s1 : !(dnx_q != tny_q);
		if (s1 == s2) begin
			num_n = {1'b0, m1_q} + {1'b0, m2_q};
			neg_n = s1;
		end else if (m1_q >= m2_q) begin
			num_n = {1'b0, m1_q - m2_q};
			neg_n = s1;
		end else begin
			num_n = {1'b0, m2_q - m1_q};
			neg_n = s2;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_avail) begin
					unique case (job.status)
						STAT_NONE:   state_n = ST_OUT;
						STAT_SIGNED: state_n = ST_DIFF;
						default:     state_n = ST_SQRT;
					endcase
				end
			end
			ST_DIFF: state_n = ST_MUL;
			ST_MUL:  state_n = ST_LEN;
			ST_LEN:  state_n = ST_SQRT;
			ST_SQRT: begin
				if (step_last) begin
					if (!sq_len_q)
						state_n = ST_OUT;
					else if (!degen)
						state_n = ST_DIV;
				end
			end
			ST_DIV:  if (step_last) state_n = ST_OUT;
			ST_OUT:  if (!out_valid_q || pop) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q <= job;
				err_q <= '0;
				stat_q <= job.status;
				op_q <= {2'b00, job.dist_sq};
				srem_q <= '0;
				root_q <= '0;
				step_q <= STEP_W'(SQRT_STEPS - 1);
				sq_len_q <= 1'b0;
			end
			ST_DIFF: begin
				tmx_q <= smag(tx);
				tmy_q <= smag(ty);
				dmx_q <= smag(dx);
				dmy_q <= smag(dy);
				tnx_q <= tx[COORD_W];
				tny_q <= ty[COORD_W];
				dnx_q <= dx[COORD_W];
				dny_q <= dy[COORD_W];
			end
			ST_MUL: begin
				sqx_q <= SQ_W'(tmx_q) * SQ_W'(tmx_q);
				sqy_q <= SQ_W'(tmy_q) * SQ_W'(tmy_q);
				m1_q <= SQ_W'(dmy_q) * SQ_W'(tmx_q);
				m2_q <= SQ_W'(dmx_q) * SQ_W'(tmy_q);
			end
			ST_LEN: begin
				op_q <= {1'b0, {1'b0, sqx_q} + {1'b0, sqy_q}};
				srem_q <= '0;
				root_q <= '0;
				step_q <= STEP_W'(SQRT_STEPS - 1);
				sq_len_q <= 1'b1;
				num_q <= num_n;
				neg_q <= neg_n;
			end
			ST_SQRT: begin
				if (!step_last) begin
					op_q <= op_q << 2;
					srem_q <= srem_n;
					root_q <= root_n;
					step_q <= step_q - 1'b1;
				end else if (!sq_len_q) begin
					err_q <= sat_pos(root_n);
				end else if (degen) begin
					// short tangent: fall back to the plain distance
					stat_q <= STAT_DEGEN;
					op_q <= {2'b00, job_q.dist_sq};
					srem_q <= '0;
					root_q <= '0;
					step_q <= STEP_W'(SQRT_STEPS - 1);
					sq_len_q <= 1'b0;
				end else begin
					len_q <= root_n;
					drem_q <= '0;
					quo_q <= '0;
					step_q <= STEP_W'(DIV_STEPS - 1);
				end
			end
			ST_DIV: begin
				num_q <= num_q << 1;
				drem_q <= drem_n;
				quo_q <= quo_n;
				step_q <= step_q - 1'b1;
				if (step_last)
					err_q <= div_err;
			end
			ST_OUT: begin
				if (load_out) begin
					out_err_q <= err_q;
					out_stat_q <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

endmodule

/* rtl/lotp_checker.sv */
module lotp_checker import lotp_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      push,
	input logic                      full,
	input logic                      cmd,
	input logic signed [COORD_W-1:0] pos_x,
	input logic signed [COORD_W-1:0] pos_y,
	input logic                      last_point,
	input logic                      empty,
	input logic                      pop,
	input logic signed [COORD_W-1:0] lateral_error,
	input logic [1:0]                status,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [CFG_W-1:0]          cfg_data
);

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(lateral_error) && $stable(status)))
		else $error("result changed while waiting");

	// an empty query reports zero error
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == STAT_NONE) |-> (lateral_error == '0))
		else $error("empty query with nonzero error");

	// distance fallbacks are never negative
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (status == STAT_SINGLE || status == STAT_DEGEN)) |->
		!lateral_error[COORD_W-1])
		else $error("negative distance");

endmodule

bind lateral_offset_to_polyline lotp_checker u_chk (.*);

/* dv/lateral_offset_checker.sv */
module lateral_offset_checker import lotp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic                      full,
	input  logic                      cmd,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic                      last_point,
	input  logic                      empty,
	input  logic                      pop,
	input  logic signed [COORD_W-1:0] lateral_error,
	input  logic [1:0]                status,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_W-1:0]          cfg_data,
	output int                        mismatches,
	output int                        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [COORD_W-1:0] err;
		logic [1:0]         stat;
	} lane_answer_t;

	lane_answer_t answer_q[$];

	logic [CFG_W-1:0] min_len;
	longint           veh_x, veh_y;
	logic [63:0]      best_d2;
	lotp_point_t      best_pt, before_pt, after_pt, prev_pt;
	int unsigned      pt_cnt;
	bit               has_before, succ_pending, has_after;

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [64:0] square_sum(input longint a, input longint b);
		logic [63:0] ma, mb;
		ma = magnitude(a);
		mb = magnitude(b);
		return {1'b0, ma * ma} + {1'b0, mb * mb};
	endfunction

	function automatic logic [33:0] floor_sqrt(input logic [65:0] v);
		logic [67:0] rem, trial;
		logic [33:0] root;
		rem = '0;
		root = '0;
		for (int k = 32; k >= 0; k--) begin
			rem = {rem[65:0], v[2*k +: 2]};
			trial = ({34'b0, root} << 2) | 68'd1;
			if (rem >= trial) begin
				rem -= trial;
				root = {root[32:0], 1'b1};
			end else begin
				root = {root[32:0], 1'b0};
			end
		end
		return root;
	endfunction

	function automatic logic [COORD_W-1:0] nearest_distance();
		logic [33:0] r;
		r = floor_sqrt({2'b0, best_d2});
		return (r > MAX_POS) ? MAX_POS : r[COORD_W-1:0];
	endfunction

	// cross product over tangent length, truncated toward zero, saturated
	function automatic logic [COORD_W-1:0] signed_offset(input longint dx, input longint dy,
		input longint tx, input longint ty, input logic [33:0] len);
		logic [63:0] m1, m2;
		logic [64:0] num, q;
		bit          s1, s2, neg;
		m1 = magnitude(dy) * magnitude(tx);
		m2 = magnitude(dx) * magnitude(ty);
		s1 = (dy < 0) != (tx < 0);
		s2 = !((dx < 0) != (ty < 0));
		if (m1 == 0) s1 = s2;
		if (m2 == 0) s2 = s1;
		if (s1 == s2) begin
			num = {1'b0, m1} + {1'b0, m2};
			neg = s1;
		end else if (m1 >= m2) begin
			num = {1'b0, m1 - m2};
			neg = s1;
		end else begin
			num = {1'b0, m2 - m1};
			neg = s2;
		end
		q = num / {31'b0, len};
		if (q > {33'b0, CAP}) q = {33'b0, CAP} + 65'd1;
		if (neg) begin
			if (q > {33'b0, CAP}) q = {33'b0, CAP};
			return -q[COORD_W-1:0];
		end
		return (q > {33'b0, MAX_POS}) ? MAX_POS : q[COORD_W-1:0];
	endfunction

	function automatic void clear_track();
		best_d2 = '1;
		best_pt = '0;
		before_pt = '0;
		after_pt = '0;
		prev_pt = '0;
		pt_cnt = 0;
		has_before = 0;
		succ_pending = 0;
		has_after = 0;
	endfunction

	function automatic void track_request(input logic c, input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y, input logic fin);
		lotp_point_t  p;
		logic [64:0]  d2;
		logic [33:0]  len;
		longint       bx, by, tx, ty;
		lane_answer_t a;
		if (c == CMD_POS) begin
			veh_x = longint'(x);
			veh_y = longint'(y);
			clear_track();
			if (fin) begin
				a.err = '0;
				a.stat = STAT_NONE;
				answer_q.push_back(a);
			end
			return;
		end
		p.x = x;
		p.y = y;
		d2 = square_sum(longint'(x) - veh_x, longint'(y) - veh_y);
		if (d2[64]) d2 = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
		if (pt_cnt == 0 || d2[63:0] < best_d2) begin
			before_pt = prev_pt;
			best_pt = p;
			best_d2 = d2[63:0];
			has_before = (pt_cnt != 0);
			has_after = 0;
			succ_pending = 1;
		end else if (succ_pending) begin
			after_pt = p;
			succ_pending = 0;
			has_after = 1;
		end
		prev_pt = p;
		if (pt_cnt < 2) pt_cnt++;
		if (!fin) return;
		bx = longint'(best_pt.x);
		by = longint'(best_pt.y);
		if (pt_cnt < 2) begin
			a.stat = STAT_SINGLE;
			a.err = nearest_distance();
		end else begin
			// use the backward tangent when the nearest point has no successor
			if (has_after) begin
				tx = longint'(after_pt.x) - bx;
				ty = longint'(after_pt.y) - by;
			end else begin
				tx = bx - longint'(before_pt.x);
				ty = by - longint'(before_pt.y);
			end
			len = floor_sqrt({1'b0, square_sum(tx, ty)});
			if (len == 0 || len < {18'b0, min_len}) begin
				a.stat = STAT_DEGEN;
				a.err = nearest_distance();
			end else begin
				a.stat = STAT_SIGNED;
				a.err = signed_offset(veh_x - bx, veh_y - by, tx, ty, len);
			end
		end
		clear_track();
		answer_q.push_back(a);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len = MIN_LEN_RESET;
			veh_x = 0;
			veh_y = 0;
			clear_track();
			answer_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) min_len = cfg_data;
			if (push && !full) track_request(cmd, pos_x, pos_y, last_point);
			if (pop && !empty) begin
				if (answer_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: error %h status %0d", lateral_error, status);
				end else begin
					lane_answer_t a;
					a = answer_q.pop_front();
					if (a.err !== lateral_error || a.stat !== status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: error exp %h got %h, status exp %0d got %0d",
								a.err, lateral_error, a.stat, status);
					end
				end
			end
			outstanding = answer_q.size();
		end
	end

endmodule

/* dv/tb_lateral_offset_to_polyline.sv */
module tb_lateral_offset_to_polyline import lotp_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_WAIT  = 150;

	logic                      clk;
	logic                      arst_n;
	logic                      push;
	logic                      full;
	logic                      cmd;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic                      last_point;
	logic                      empty;
	logic                      pop;
	logic signed [COORD_W-1:0] lateral_error;
	logic [1:0]                status;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_W-1:0]          cfg_data;

	int mismatches;
	int outstanding;

	// idling percentages for the current phase, and the long receiver hold-off
	int  send_gap_pct;
	int  recv_stall_pct;
	bit  recv_hold;

	lateral_offset_to_polyline dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y),
		.last_point(last_point),
		.empty(empty), .pop(pop), .lateral_error(lateral_error), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	lateral_offset_checker chk (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .cmd(cmd), .pos_x(pos_x), .pos_y(pos_y),
		.last_point(last_point),
		.empty(empty), .pop(pop), .lateral_error(lateral_error), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: pop at random, except during a hold-off.
	always @(posedge clk) begin
		pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: count cycles in which no request, result or write is taken.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Offer one request and hold it until the block takes it.
	task automatic send_request(input logic c, input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic fin);
		while ($urandom_range(99) < send_gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		pos_x <= x;
		pos_y <= y;
		last_point <= fin;
		do @(posedge clk); while (full);
	endtask

	// Drain all results, then let the back end settle before touching config.
	task automatic wait_drained();
		push <= 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_min_len(input logic [CFG_W-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] spread_value(input int bits);
		logic [COORD_W-1:0] r;
		r = $urandom;
		if (bits >= COORD_W) return r;
		// sign-extended random of the given width
		return COORD_W'($signed(r << (COORD_W - bits)) >>> (COORD_W - bits));
	endfunction

	// One polyline against a vehicle: points run along a line with jitter,
	// with the odd repeated point or wild point mixed in.
	task automatic lane_query(input int n, input bit with_pos);
		logic [COORD_W-1:0] vx, vy, sx, sy, dx, dy, px, py;
		int bits;
		vx = ($urandom_range(7) == 0) ? spread_value(32) : spread_value(24);
		vy = ($urandom_range(7) == 0) ? spread_value(32) : spread_value(24);
		bits = ($urandom_range(9) == 0) ? 32 : $urandom_range(4, 22);
		dx = spread_value(bits);
		dy = spread_value(bits);
		sx = vx - dx * (n / 2) + spread_value(bits);
		sy = vy - dy * (n / 2) + spread_value(bits);
		if (with_pos || n == 0) send_request(CMD_POS, vx, vy, n == 0);
		px = sx;
		py = sy;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(15))
				0: begin px = spread_value(32); py = spread_value(32); end
				1, 2: ; // repeat the previous point
				default: begin
					px = sx + dx * i + spread_value(bits / 2 + 1);
					py = sy + dy * i + spread_value(bits / 2 + 1);
				end
			endcase
			send_request(CMD_POINT, px, py, i == n - 1);
		end
	endtask

	task automatic random_phase(input int queries);
		int n;
		for (int q = 0; q < queries; q++) begin
			case ($urandom_range(9))
				0: n = 0;
				1: n = 1;
				2: n = $urandom_range(9, 20);
				default: n = $urandom_range(2, 8);
			endcase
			// a stray position without points, then a fresh query
			if ($urandom_range(19) == 0) send_request(CMD_POS, $urandom, $urandom, 1'b0);
			lane_query(n, $urandom_range(9) != 0);
			if (q == queries / 2 && $urandom_range(1)) wait_drained();
		end
	endtask

	localparam logic [COORD_W-1:0] ONE = COORD_W'(1 << 16);

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		cmd = CMD_POS;
		pos_x = '0;
		pos_y = '0;
		last_point = 1'b0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		recv_hold = 1'b0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a point before any position is measured from the origin.
		send_request(CMD_POINT, 5 * ONE, 3 * ONE, 1'b1);
		// Empty query.
		send_request(CMD_POS, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		// Extreme coordinates: distances saturate.
		send_request(CMD_POS, 32'h8000_0000, 32'h8000_0000, 1'b0);
		send_request(CMD_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_request(CMD_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		send_request(CMD_POINT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_request(CMD_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		// Degenerate tangent: repeated point.
		send_request(CMD_POS, '0, ONE, 1'b0);
		send_request(CMD_POINT, ONE, '0, 1'b0);
		send_request(CMD_POINT, ONE, '0, 1'b1);
		// Nearest is the final point: backward tangent.
		send_request(CMD_POS, '0, ONE, 1'b0);
		send_request(CMD_POINT, -2 * ONE, '0, 1'b0);
		send_request(CMD_POINT, -ONE, '0, 1'b0);
		send_request(CMD_POINT, '0, '0, 1'b1);
		// Tie: first equidistant point is kept; vehicle right of lane.
		send_request(CMD_POS, '0, -ONE, 1'b0);
		send_request(CMD_POINT, -ONE, '0, 1'b0);
		send_request(CMD_POINT, ONE, '0, 1'b0);
		send_request(CMD_POINT, 3 * ONE, ONE, 1'b1);
		// Points after a final point reuse the same vehicle.
		send_request(CMD_POINT, 2 * ONE, 2 * ONE, 1'b0);
		send_request(CMD_POINT, 2 * ONE, 5 * ONE, 1'b1);

		// Phase 1: no idling, min length zero, receiver held off long.
		write_min_len('0);
		fork
			begin
				recv_hold = 1'b1;
				repeat (400) @(posedge clk);
				recv_hold = 1'b0;
			end
		join_none
		random_phase(35);

		// Phase 2: sender gaps, largest min length.
		write_min_len(16'hFFFF);
		send_gap_pct = 51;
		random_phase(35);

		// Phase 3: receiver stalls, random min length.
		write_min_len(CFG_W'($urandom_range(2, 65534)));
		send_gap_pct = 0;
		recv_stall_pct = 51;
		random_phase(35);

		// Phase 4: both idle, back to the reset value.
		write_min_len(MIN_LEN_RESET);
		send_gap_pct = 30;
		recv_stall_pct = 30;
		random_phase(35);

		wait_drained();
		if (mismatches == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/lotp_pkg.sv
rtl/lotp_front.sv
rtl/lotp_fifo.sv
rtl/lotp_back.sv
rtl/lateral_offset_to_polyline.sv
rtl/lotp_checker.sv
dv/lateral_offset_checker.sv
dv/tb_lateral_offset_to_polyline.sv
